// ===== design/tbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_SET    = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_QUERY  = 3'd4
  } action_e;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [31:0] END_FOR_ZERO  = 32'hFFFF_FFFE;
  localparam logic [7:0]  DIVISOR_RESET = 8'd100;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] elapsed;
    logic [31:0] end_cnt;
  } slot_t;

endpackage

`default_nettype wire

// ===== design/tbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/timer_bank_with_prescaler_unit.sv =====
// Bank of NUM_TIMERS software timer slots behind a base-tick prescaler. Each word in
// carries an action (tick, create, set, delete, query) and a slot index, and gives back
// exactly one word: whether the action took effect, plus the addressed slot's mode,
// elapsed count and remaining count after it. Slot contents live in a single RAM with one
// write and one registered read port; a per-slot registered bit in flops stands in for a
// cleared slot, so no clearing pass is needed after reset. Create, set, delete, query and
// a tick that does not fire the prescaler load the result register through a slot read,
// then an update step; no new word is taken until that word's update is done. A tick
// that fires the prescaler sweeps every slot through the one read/increment/compare/write
// path, one slot per cycle, then reads and updates the addressed slot the same way before
// it takes a new word. While the previous result is not taken the update step waits. A
// new word is accepted while the previous result still waits in the output register.
// tick_divisor may be written at any time the bank is idle.
`timescale 1ns / 1ps
`default_nettype none

module timer_bank_with_prescaler_unit
  import tbp_pkg::*;
#(
  parameter int NUM_TIMERS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [4:0]  timer_index_i,
  input  wire logic [1:0]  new_mode_i,
  input  wire logic [31:0] set_time_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic [1:0]       status_o,
  output logic [31:0]      elapsed_o,
  output logic [31:0]      remaining_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_tick_divisor_i
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] N_CNT = CW'(NUM_TIMERS);
  localparam logic [8:0]    N_IDX = 9'(NUM_TIMERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_MODIFY
  } state_e;

  state_e          state_q;
  logic [2:0]      action_q;
  logic [4:0]      index_q;
  logic [1:0]      mode_q;
  logic [31:0]     time_q;
  logic [7:0]      prescale_q;
  logic [7:0]      divisor_q;
  logic [NUM_TIMERS-1:0] reg_q;
  logic [CW-1:0]   cnt_q;
  logic            pend_q;
  logic [AW-1:0]   pend_addr_q;
  logic            out_valid_q;
  logic            accepted_q;
  logic [1:0]      status_q;
  logic [31:0]     elapsed_q;
  logic [31:0]     remaining_q;

  logic [8:0]      idx_ext;
  logic            in_range;
  logic [AW-1:0]   slot_addr;
  logic [7:0]      prescale_nxt;
  logic            fire;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  slot_t           ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t           rd_slot;

  logic            slot_reg;
  slot_t           cur;
  slot_t           armed;
  slot_t           res;
  logic            acc;
  logic            arm_wr;
  logic            set_reg;
  logic            clr_reg;
  logic            out_free;
  logic            commit;

  logic            sw_live;
  logic [31:0]     sw_el;
  slot_t           sw_new;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign status_o    = status_q;
  assign elapsed_o   = elapsed_q;
  assign remaining_o = remaining_q;

  assign idx_ext   = {4'b0, index_q};
  assign in_range  = (idx_ext < N_IDX);
  assign slot_addr = idx_ext[AW-1:0];

  assign prescale_nxt = prescale_q + 8'd1;
  assign fire         = (prescale_nxt >= divisor_q);

  assign rd_slot  = slot_t'(ram_rdata);
  assign slot_reg = in_range && reg_q[slot_addr];
  assign cur      = slot_reg ? rd_slot : '0;

  always_comb begin
    armed.mode    = (mode_q == MODE_RSVD) ? MODE_IDLE : mode_q;
    armed.elapsed = '0;
    armed.end_cnt = (time_q != '0) ? time_q : END_FOR_ZERO;
  end

  always_comb begin
    acc     = 1'b0;
    res     = cur;
    arm_wr  = 1'b0;
    set_reg = 1'b0;
    clr_reg = 1'b0;
    unique case (action_e'(action_q))
      ACT_TICK: begin
        acc = 1'b1;
      end
      ACT_CREATE: begin
        if (in_range) begin
          acc     = 1'b1;
          arm_wr  = 1'b1;
          set_reg = 1'b1;
          res     = armed;
        end
      end
      ACT_SET: begin
        if (slot_reg) begin
          acc    = 1'b1;
          arm_wr = 1'b1;
          res    = armed;
        end
      end
      ACT_DELETE: begin
        if (slot_reg) begin
          acc     = 1'b1;
          clr_reg = 1'b1;
          res     = '0;
        end
      end
      ACT_QUERY: begin
        acc = in_range;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == ST_MODIFY) && out_free;

  // sweep: data read last cycle is updated and written back while the next slot is read
  assign sw_live = pend_q && reg_q[pend_addr_q] && (rd_slot.mode == MODE_RUN);
  assign sw_el   = rd_slot.elapsed + 32'd1;
  always_comb begin
    sw_new.mode    = (sw_el >= rd_slot.end_cnt) ? MODE_DONE : MODE_RUN;
    sw_new.elapsed = sw_el;
    sw_new.end_cnt = rd_slot.end_cnt;
  end

  assign ram_we    = sw_live || (commit && arm_wr);
  assign ram_waddr = commit ? slot_addr : pend_addr_q;
  assign ram_wdata = commit ? armed : sw_new;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = slot_addr;
    unique case (state_q)
      ST_SWEEP: begin
        ram_re    = (cnt_q != N_CNT);
        ram_raddr = cnt_q[AW-1:0];
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  tbp_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(NUM_TIMERS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= '0;
      index_q     <= '0;
      mode_q      <= '0;
      time_q      <= '0;
      prescale_q  <= '0;
      divisor_q   <= DIVISOR_RESET;
      reg_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      status_q    <= '0;
      elapsed_q   <= '0;
      remaining_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        divisor_q <= cfg_tick_divisor_i;
      end

      if (commit) begin
        out_valid_q <= 1'b1;
        accepted_q  <= acc;
        status_q    <= res.mode;
        elapsed_q   <= res.elapsed;
        remaining_q <= res.end_cnt - res.elapsed;
        if (set_reg) begin
          reg_q[slot_addr] <= 1'b1;
        end
        if (clr_reg) begin
          reg_q[slot_addr] <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            action_q <= action_i;
            index_q  <= timer_index_i;
            mode_q   <= new_mode_i;
            time_q   <= set_time_i;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            state_q  <= ST_READ;
            if (action_i == ACT_TICK) begin
              if (fire) begin
                prescale_q <= '0;
                state_q    <= ST_SWEEP;
              end else begin
                prescale_q <= prescale_nxt;
              end
            end
          end
        end
        ST_SWEEP: begin
          if (cnt_q == N_CNT) begin
            pend_q  <= 1'b0;
            state_q <= ST_READ;
          end else begin
            pend_q      <= 1'b1;
            pend_addr_q <= cnt_q[AW-1:0];
            cnt_q       <= cnt_q + 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_MODIFY;
        end
        ST_MODIFY: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tbp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tbp_checker
  import tbp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        accepted_o,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] elapsed_o,
  input wire logic [31:0] remaining_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o)
      && $stable(status_o) && $stable(elapsed_o) && $stable(remaining_o))
    else $error("result word changed while stalled");

  // one word at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after acceptance");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == MODE_IDLE || status_o == MODE_RUN
      || status_o == MODE_DONE)
    else $error("reserved mode reported");

  // idle slots never count
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == MODE_IDLE |-> elapsed_o == '0)
    else $error("idle slot with nonzero elapsed count");

  // a running slot has not yet reached its end count
  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == MODE_RUN |-> remaining_o != '0)
    else $error("running slot with nothing remaining");

endmodule

bind timer_bank_with_prescaler_unit tbp_checker u_tbp_checker (.*);

`default_nettype wire

// ===== tb/timer_bank_with_prescaler_unit_test.sv =====
`timescale 1ns / 1ps

module timer_bank_with_prescaler_unit_test;
  import tbp_pkg::*;

  localparam int NUM_SLOTS = 32;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int BLOCKS = 6;
  localparam int WORDS_PER_BLOCK = 255;
  localparam int MAX_SHOWN = 10;
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] ACT_LAST_UNUSED = 3'd7;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic [31:0] elapsed;
    logic [31:0] remaining;
  } slot_report_t;

  // mirror of the slot bank; works out the report word for every word taken in
  class slot_ledger;
    logic         used [NUM_SLOTS];
    logic [1:0]   mode [NUM_SLOTS];
    logic [31:0]  elapsed [NUM_SLOTS];
    logic [31:0]  end_cnt [NUM_SLOTS];
    logic [7:0]   prescale;
    logic [7:0]   divisor;
    slot_report_t due_words[$];
    int           errors;

    function new();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        used[s] = 1'b0;
        mode[s] = MODE_IDLE;
        elapsed[s] = '0;
        end_cnt[s] = '0;
      end
      prescale = '0;
      divisor = DIVISOR_RESET;
      errors = 0;
    endfunction

    function void set_divisor(logic [7:0] d);
      divisor = d;
    endfunction

    function void arm(int s, logic [1:0] m, logic [31:0] t);
      end_cnt[s] = (t != '0) ? t : END_FOR_ZERO;
      elapsed[s] = '0;
      mode[s] = (m == MODE_RSVD) ? MODE_IDLE : m;
    endfunction

    function void advance_running();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (used[s] && mode[s] == MODE_RUN) begin
          elapsed[s] = elapsed[s] + 32'd1;
          if (elapsed[s] >= end_cnt[s]) mode[s] = MODE_DONE;
        end
      end
    endfunction

    function void note_word(logic [2:0] act, logic [4:0] idx, logic [1:0] m,
                            logic [31:0] t);
      logic [7:0]   nxt;
      logic         took;
      int           s;
      slot_report_t w;
      s = int'(idx);
      took = 1'b0;
      case (act)
        ACT_TICK: begin
          took = 1'b1;
          nxt = prescale + 8'd1;
          if (nxt >= divisor) begin
            prescale = '0;
            advance_running();
          end else begin
            prescale = nxt;
          end
        end
        ACT_CREATE: begin
          used[s] = 1'b1;
          arm(s, m, t);
          took = 1'b1;
        end
        ACT_SET: begin
          if (used[s]) begin
            arm(s, m, t);
            took = 1'b1;
          end
        end
        ACT_DELETE: begin
          if (used[s]) begin
            used[s] = 1'b0;
            mode[s] = MODE_IDLE;
            elapsed[s] = '0;
            end_cnt[s] = '0;
            took = 1'b1;
          end
        end
        ACT_QUERY: took = 1'b1;
        default: ;
      endcase
      w.accepted = took;
      w.status = mode[s];
      w.elapsed = elapsed[s];
      w.remaining = end_cnt[s] - elapsed[s];
      due_words.push_back(w);
    endfunction

    function void miss(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
    endfunction

    function void check_word(logic acc, logic [1:0] st, logic [31:0] el, logic [31:0] rem);
      slot_report_t want;
      if (due_words.size() == 0) begin
        miss($sformatf("word with nothing outstanding: acc %0d st %0d el %0h rem %0h",
                       acc, st, el, rem));
        return;
      end
      want = due_words.pop_front();
      if (acc !== want.accepted)
        miss($sformatf("accepted exp %0d got %0d", want.accepted, acc));
      if (st !== want.status)
        miss($sformatf("status exp %0d got %0d", want.status, st));
      if (el !== want.elapsed)
        miss($sformatf("elapsed exp %0h got %0h", want.elapsed, el));
      if (rem !== want.remaining)
        miss($sformatf("remaining exp %0h got %0h", want.remaining, rem));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [4:0]  timer_index_i;
  logic [1:0]  new_mode_i;
  logic [31:0] set_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        accepted_o;
  logic [1:0]  status_o;
  logic [31:0] elapsed_o;
  logic [31:0] remaining_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_tick_divisor_i;

  slot_ledger book = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  timer_bank_with_prescaler_unit #(
    .NUM_TIMERS(NUM_SLOTS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .timer_index_i     (timer_index_i),
    .new_mode_i        (new_mode_i),
    .set_time_i        (set_time_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .status_o          (status_o),
    .elapsed_o         (elapsed_o),
    .remaining_o       (remaining_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_tick_divisor_i(cfg_tick_divisor_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check what the bank hands over, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.check_word(accepted_o, status_o, elapsed_o, remaining_o);
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic push_word(input logic [2:0] act, input logic [4:0] idx,
                           input logic [1:0] m, input logic [31:0] t);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    timer_index_i <= idx;
    new_mode_i <= m;
    set_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_word(act, idx, m, t);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.due_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_divisor(input logic [7:0] d);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_tick_divisor_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    book.set_divisor(d);
  endtask

  // mostly ticks and arming on a handful of slots so timers actually run out
  task automatic send_random_word();
    logic [2:0]  act;
    logic [4:0]  idx;
    logic [1:0]  m;
    logic [31:0] t;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) act = ACT_TICK;
    else if (pick < 60) act = ACT_CREATE;
    else if (pick < 75) act = ACT_SET;
    else if (pick < 82) act = ACT_DELETE;
    else if (pick < 95) act = ACT_QUERY;
    else act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    if ($urandom_range(0, 3) == 0) idx = 5'($urandom_range(0, NUM_SLOTS - 1));
    else idx = 5'($urandom_range(0, 5));
    m = $urandom_range(0, 1) ? MODE_RUN : 2'($urandom_range(MODE_IDLE, MODE_RSVD));
    pick = $urandom_range(0, 9);
    if (pick < 6) t = $urandom_range(1, 12);
    else if (pick == 6) t = '0;
    else if (pick == 7) t = 32'hFFFF_FFFF;
    else t = $urandom();
    push_word(act, idx, m, t);
  endtask

  initial begin
    logic [7:0] divisors [BLOCKS];
    divisors = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd2, 8'd100};
    divisors[4] = 8'($urandom_range(2, 20));
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    action_i <= ACT_TICK;
    timer_index_i <= '0;
    new_mode_i <= MODE_IDLE;
    set_time_i <= '0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_tick_divisor_i <= DIVISOR_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // divisor still at its reset value here, so ticks only count
    push_word(ACT_CREATE, 5'd0, MODE_RUN, 32'd3);
    push_word(ACT_CREATE, 5'd31, MODE_RUN, 32'd0);
    push_word(ACT_SET, 5'd5, MODE_RUN, 32'd7);
    push_word(ACT_DELETE, 5'd5, MODE_IDLE, 32'd0);
    push_word(ACT_FIRST_UNUSED, 5'd0, MODE_RUN, 32'd1);
    push_word(ACT_LAST_UNUSED, 5'd31, MODE_RSVD, 32'hFFFF_FFFF);
    push_word(ACT_QUERY, 5'd31, MODE_IDLE, 32'd0);
    push_word(ACT_CREATE, 5'd7, MODE_RSVD, 32'hFFFF_FFFF);
    push_word(ACT_CREATE, 5'd8, MODE_DONE, 32'd1);
    push_word(ACT_TICK, 5'd0, MODE_IDLE, 32'd0);
    push_word(ACT_TICK, 5'd31, MODE_RSVD, 32'hFFFF_FFFF);

    // zero divisor: every tick sweeps
    write_divisor(8'd0);
    repeat (4) push_word(ACT_TICK, 5'd0, MODE_IDLE, 32'd0);
    push_word(ACT_SET, 5'd0, MODE_RUN, 32'd2);
    push_word(ACT_TICK, 5'd0, MODE_IDLE, 32'd0);
    push_word(ACT_QUERY, 5'd0, MODE_IDLE, 32'd0);
    push_word(ACT_DELETE, 5'd31, MODE_IDLE, 32'd0);
    push_word(ACT_QUERY, 5'd31, MODE_IDLE, 32'd0);
    push_word(ACT_CREATE, 5'd0, MODE_IDLE, 32'h8000_0000);
    push_word(ACT_SET, 5'd7, MODE_RSVD, 32'd5);
    push_word(ACT_CREATE, 5'd1, MODE_RUN, 32'd1);
    push_word(ACT_TICK, 5'd1, MODE_IDLE, 32'd0);
    push_word(ACT_QUERY, 5'd1, MODE_IDLE, 32'd0);

    for (int b = 0; b < BLOCKS; b++) begin
      write_divisor(divisors[b]);
      send_idle_pct = (b < 2) ? 23 : (b < 4) ? 52 : 0;
      recv_idle_pct = (b < 2) ? 52 : (b < 4) ? 23 : 0;
      repeat (WORDS_PER_BLOCK) begin
        // now and then hold off until the bank has caught up
        if ($urandom_range(0, 199) == 0) wait_for_results();
        send_random_word();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
